// File: rtl/core/otb_pkg.sv
// shared types and constants for the one-shot timer bank
// no dependencies; imported by one_shot_timer_bank_unit
package otb_pkg;

	localparam int TIMER_COUNT = 8;
	localparam int SLOT_W      = 3;
	localparam int CNT_W       = 4;
	localparam int TICK_W      = 32;
	localparam int SIG_W       = 32;
	localparam int AGENT_W     = 4;

	typedef enum logic [2:0] {
		FN_TICK     = 3'd0,
		FN_ARM      = 3'd1,
		FN_DISARM   = 3'd2,
		FN_REGISTER = 3'd3,
		FN_CLEAR    = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		KIND_DONE     = 2'd0,
		KIND_EXPIRED  = 2'd1,
		KIND_REJECTED = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [SLOT_W-1:0]  slot;
		logic [SIG_W-1:0]   sig;
		logic [AGENT_W-1:0] agent;
		logic               last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

// File: rtl/core/one_shot_timer_bank_unit.sv
// one-shot timer bank: register, arm, disarm, tick and clear-all of eight timers
// a tick walks the slots one per cycle, unless the receiver stalls, through a single shared decrementer
// depends on otb_pkg
//
// usage: operations arrive as words on the s_axis channel, func in tuser and
// the operands in tdata. results leave on the m_axis channel, kind in tuser,
// the final result of an operation marked by tlast.
// arm, disarm, register, clear-all and unknown codes place their one result in
// the output register from the exec state, once it is free. a tick walks all
// eight slots, one per cycle unless the receiver stalls, through the one
// decrementer; each expiry is held in the pending register so the last can be
// marked, and leaves when the next expiry is found or when the walk ends,
// giving up to eight results. the block takes the next word only when back
// in idle.
// a word is accepted while a finished result still waits in the output
// register. when the receiver stalls, the walk holds on the slot whose expiry
// cannot be placed, and nothing is lost.
// reset empties the bank: no slot registered, none armed, no result pending.
module one_shot_timer_bank_unit
	import otb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // timer_index, timeout_ticks, signal_value, agent_id, pad
	input  logic [2:0]  s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // slot, event_signal, event_agent, pad
	output logic [1:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast
);

	state_t                   state_q, state_d;
	logic [SLOT_W-1:0]        walk_q, walk_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [TIMER_COUNT-1:0]   armed_q, armed_d;
	logic                     pend_valid_q, pend_valid_d;
	result_t                  pend_q, pend_d;
	logic                     out_valid_q;
	result_t                  out_q;

	logic [TICK_W-1:0]        rem_q [TIMER_COUNT];
	logic [SIG_W-1:0]         sig_q [TIMER_COUNT];
	logic [AGENT_W-1:0]       agent_q [TIMER_COUNT];

	logic [2:0]               op_func_q;
	logic [SLOT_W-1:0]        op_idx_q;
	logic [TICK_W-1:0]        op_timeout_q;
	logic [SIG_W-1:0]         op_sig_q;
	logic [AGENT_W-1:0]       op_agent_q;

	logic                     accept;
	logic                     out_free;
	logic                     push;
	result_t                  push_res;
	logic                     rem_we;
	logic [SLOT_W-1:0]        rem_waddr;
	logic [TICK_W-1:0]        rem_wdata;
	logic                     rem_clr;
	logic                     reg_we;
	logic [TICK_W-1:0]        dec;
	logic                     active;
	logic                     expire;
	logic                     idx_ok;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign idx_ok = ({1'b0, op_idx_q} < count_q);
	assign active = ({1'b0, walk_q} < count_q) && armed_q[walk_q];
	assign dec    = rem_q[walk_q] - TICK_W'(1);
	assign expire = active && (dec == '0);

	always_comb begin
		state_d      = state_q;
		walk_d       = walk_q;
		count_d      = count_q;
		armed_d      = armed_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		push         = 1'b0;
		push_res     = '{kind: KIND_DONE, slot: '0, sig: '0, agent: '0, last: 1'b1};
		rem_we       = 1'b0;
		rem_waddr    = op_idx_q;
		rem_wdata    = '0;
		rem_clr      = 1'b0;
		reg_we       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (op_func_q == FN_TICK) begin
					state_d      = ST_WALK;
					walk_d       = '0;
					pend_valid_d = 1'b0;
				end else if (out_free) begin
					state_d = ST_IDLE;
					push    = 1'b1;
					unique case (op_func_q)
						FN_ARM: begin
							push_res.slot = op_idx_q;
							if (idx_ok && (op_timeout_q != '0)) begin
								rem_we             = 1'b1;
								rem_wdata          = op_timeout_q;
								armed_d[op_idx_q]  = 1'b1;
							end else begin
								push_res.kind = KIND_REJECTED;
							end
						end
						FN_DISARM: begin
							push_res.slot = op_idx_q;
							if (idx_ok) begin
								rem_we            = 1'b1;
								armed_d[op_idx_q] = 1'b0;
							end else begin
								push_res.kind = KIND_REJECTED;
							end
						end
						FN_REGISTER: begin
							if (count_q < CNT_W'(TIMER_COUNT)) begin
								push_res.slot = count_q[SLOT_W-1:0];
								reg_we        = 1'b1;
								rem_we        = 1'b1;
								rem_waddr     = count_q[SLOT_W-1:0];
								armed_d[count_q[SLOT_W-1:0]] = 1'b0;
								count_d       = count_q + CNT_W'(1);
							end else begin
								push_res.kind = KIND_REJECTED;
							end
						end
						FN_CLEAR: begin
							count_d = '0;
							armed_d = '0;
							rem_clr = 1'b1;
						end
						default: begin
							push_res.kind = KIND_REJECTED;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (!(expire && pend_valid_q && !out_free)) begin
					rem_waddr = walk_q;
					rem_wdata = dec;
					rem_we    = active;
					if (expire) begin
						armed_d[walk_q] = 1'b0;
						if (pend_valid_q) begin
							push     = 1'b1;
							push_res = pend_q;
						end
						pend_valid_d = 1'b1;
						pend_d       = '{kind: KIND_EXPIRED, slot: walk_q,
							sig: sig_q[walk_q], agent: agent_q[walk_q], last: 1'b0};
					end
					if (walk_q == SLOT_W'(TIMER_COUNT - 1)) begin
						state_d = ST_FINISH;
					end else begin
						walk_d = walk_q + SLOT_W'(1);
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					push    = 1'b1;
					state_d = ST_IDLE;
					if (pend_valid_q) begin
						push_res      = pend_q;
						push_res.last = 1'b1;
					end
					pend_valid_d = 1'b0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			walk_q       <= '0;
			count_q      <= '0;
			armed_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			walk_q       <= walk_d;
			count_q      <= count_d;
			armed_q      <= armed_d;
			pend_valid_q <= pend_valid_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_func_q    <= s_axis_tuser;
			op_idx_q     <= s_axis_tdata[2:0];
			op_timeout_q <= s_axis_tdata[34:3];
			op_sig_q     <= s_axis_tdata[66:35];
			op_agent_q   <= s_axis_tdata[70:67];
		end
		pend_q <= pend_d;
		if (push) begin
			out_q <= push_res;
		end
		if (rem_clr) begin
			for (int i = 0; i < TIMER_COUNT; i++) begin
				rem_q[i] <= '0;
			end
		end else if (rem_we) begin
			rem_q[rem_waddr] <= rem_wdata;
		end
		if (reg_we) begin
			sig_q[count_q[SLOT_W-1:0]]   <= op_sig_q;
			agent_q[count_q[SLOT_W-1:0]] <= op_agent_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.agent, out_q.sig, out_q.slot};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;

endmodule

// File: bench/one_shot_timer_bank_unit_tb.sv
// testbench for one_shot_timer_bank_unit: directed and random timer operations
// with random gaps and stalls, each result checked against an in-bench predictor
// depends on otb_pkg and one_shot_timer_bank_unit
module one_shot_timer_bank_unit_tb;
	import otb_pkg::*;

	localparam logic [2:0] FN_UNUSED_LO = 3'd5;
	localparam logic [2:0] FN_UNUSED_HI = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;  // timer_index, timeout_ticks, signal_value, agent_id, pad
	logic [2:0]  s_axis_tuser = '0;  // func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [39:0] m_axis_tdata;       // slot, event_signal, event_agent, pad
	logic [1:0]  m_axis_tuser;       // kind
	logic        m_axis_tlast;

	// predictor state
	int                 bank_count;
	logic               slot_armed [TIMER_COUNT];
	logic [TICK_W-1:0]  slot_ticks [TIMER_COUNT];
	logic [SIG_W-1:0]   slot_sig   [TIMER_COUNT];
	logic [AGENT_W-1:0] slot_agent [TIMER_COUNT];

	result_t pending_results[$];
	int      fail_count = 0;
	int      cycle_count = 0;
	int      stall_left = 0;
	logic    idle_on = 1'b1;

	one_shot_timer_bank_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("one_shot_timer_bank_unit test failed");
			$finish;
		end
	end

	// mostly short pauses, now and then a long one
	function automatic int pick_span();
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= pick_span() - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic result_t make_result(logic [1:0] kind, logic [SLOT_W-1:0] slot,
			logic [SIG_W-1:0] sig, logic [AGENT_W-1:0] agent, logic last);
		result_t r;
		r.kind = kind;
		r.slot = slot;
		r.sig = sig;
		r.agent = agent;
		r.last = last;
		return r;
	endfunction

	function automatic void reset_bank();
		bank_count = 0;
		for (int i = 0; i < TIMER_COUNT; i++) begin
			slot_armed[i] = 1'b0;
			slot_ticks[i] = '0;
		end
	endfunction

	function automatic void predict_timer_op(logic [2:0] fn, logic [SLOT_W-1:0] idx,
			logic [TICK_W-1:0] tmo, logic [SIG_W-1:0] sig, logic [AGENT_W-1:0] agent);
		logic [TIMER_COUNT-1:0] hits;
		hits = '0;
		unique case (fn)
			FN_TICK: begin
				for (int i = 0; i < TIMER_COUNT; i++) begin
					if (i < bank_count && slot_armed[i]) begin
						slot_ticks[i] = slot_ticks[i] - TICK_W'(1);
						if (slot_ticks[i] == '0) begin
							slot_armed[i] = 1'b0;
							hits[i] = 1'b1;
						end
					end
				end
				if (hits == '0)
					pending_results.push_back(make_result(KIND_DONE, '0, '0, '0, 1'b1));
				for (int i = 0; i < TIMER_COUNT; i++) begin
					if (hits[i])
						pending_results.push_back(make_result(KIND_EXPIRED, i[SLOT_W-1:0],
							slot_sig[i], slot_agent[i], (hits >> (i + 1)) == '0));
				end
			end
			FN_ARM: begin
				if (idx < bank_count && tmo != '0) begin
					slot_ticks[idx] = tmo;
					slot_armed[idx] = 1'b1;
					pending_results.push_back(make_result(KIND_DONE, idx, '0, '0, 1'b1));
				end else begin
					pending_results.push_back(make_result(KIND_REJECTED, idx, '0, '0, 1'b1));
				end
			end
			FN_DISARM: begin
				if (idx < bank_count) begin
					slot_ticks[idx] = '0;
					slot_armed[idx] = 1'b0;
					pending_results.push_back(make_result(KIND_DONE, idx, '0, '0, 1'b1));
				end else begin
					pending_results.push_back(make_result(KIND_REJECTED, idx, '0, '0, 1'b1));
				end
			end
			FN_REGISTER: begin
				if (bank_count < TIMER_COUNT) begin
					slot_sig[bank_count] = sig;
					slot_agent[bank_count] = agent;
					slot_ticks[bank_count] = '0;
					slot_armed[bank_count] = 1'b0;
					pending_results.push_back(make_result(KIND_DONE,
						bank_count[SLOT_W-1:0], '0, '0, 1'b1));
					bank_count++;
				end else begin
					pending_results.push_back(make_result(KIND_REJECTED, '0, '0, '0, 1'b1));
				end
			end
			FN_CLEAR: begin
				reset_bank();
				pending_results.push_back(make_result(KIND_DONE, '0, '0, '0, 1'b1));
			end
			default: pending_results.push_back(make_result(KIND_REJECTED, '0, '0, '0, 1'b1));
		endcase
	endfunction

	task automatic send_word(logic [2:0] fn, logic [SLOT_W-1:0] idx, logic [TICK_W-1:0] tmo,
			logic [SIG_W-1:0] sig, logic [AGENT_W-1:0] agent);
		int gap;
		gap = (idle_on && $urandom_range(0, 1) == 0) ? pick_span() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {1'b0, agent, sig, tmo, idx};
		do @(posedge clk); while (!s_axis_tready);
		predict_timer_op(fn, idx, tmo, sig, agent);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: kind %0d slot %0d",
					m_axis_tuser, m_axis_tdata[2:0]);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[2:0] !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, m_axis_tdata[2:0]);
					fail_count++;
				end
				if (m_axis_tdata[34:3] !== want.sig) begin
					$error("event_signal: expected %h, got %h", want.sig, m_axis_tdata[34:3]);
					fail_count++;
				end
				if (m_axis_tdata[38:35] !== want.agent) begin
					$error("event_agent: expected %0d, got %0d", want.agent, m_axis_tdata[38:35]);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("is_last: expected %0d, got %0d", want.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	task automatic test_empty_bank();
		send_word(FN_TICK, '0, '0, '0, '0);
		send_word(FN_ARM, 3'd0, 32'd1, '0, '0);
		send_word(FN_DISARM, 3'd7, '0, '0, '0);
	endtask

	task automatic test_register_full();
		logic [SIG_W-1:0] sig;
		logic [AGENT_W-1:0] agent;
		for (int i = 0; i < TIMER_COUNT; i++) begin
			sig = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
			agent = (i == 0) ? '0 : (i == 1) ? '1 : i[AGENT_W-1:0];
			send_word(FN_REGISTER, i[SLOT_W-1:0], $urandom, sig, agent);
		end
		send_word(FN_REGISTER, '0, '0, $urandom, AGENT_W'($urandom));
	endtask

	task automatic test_arm_rules();
		send_word(FN_ARM, 3'd0, '0, '0, '0);
		for (int i = 0; i < TIMER_COUNT - 1; i++)
			send_word(FN_ARM, i[SLOT_W-1:0], 32'd1, '0, '0);
		send_word(FN_ARM, 3'd7, '1, '0, '0);
		send_word(FN_ARM, 3'd7, 32'd1, '0, '0);
		send_word(FN_TICK, '0, '0, '0, '0);
		send_word(FN_DISARM, 3'd6, '0, '0, '0);
	endtask

	task automatic test_odd_codes();
		send_word(FN_UNUSED_LO, '1, '1, '1, '1);
		send_word(FN_UNUSED_HI, '0, '0, '0, '0);
		send_word(FN_CLEAR, '1, '1, '1, '1);
	endtask

	task automatic test_random_ops(int count);
		int pick;
		logic [2:0] fn;
		logic [SLOT_W-1:0] idx;
		logic [TICK_W-1:0] tmo;
		for (int n = 0; n < count; n++) begin
			if (n % 20 == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 35)
				fn = FN_TICK;
			else if (pick < 65)
				fn = FN_ARM;
			else if (pick < 75)
				fn = FN_DISARM;
			else if (pick < 88)
				fn = FN_REGISTER;
			else if (pick < 93)
				fn = FN_CLEAR;
			else
				fn = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
			if (bank_count > 0 && $urandom_range(0, 4) != 0)
				idx = SLOT_W'($urandom_range(0, bank_count - 1));
			else
				idx = SLOT_W'($urandom_range(0, TIMER_COUNT - 1));
			case ($urandom_range(0, 9))
				0: tmo = '0;
				1: tmo = $urandom;
				default: tmo = $urandom_range(1, 4);
			endcase
			send_word(fn, idx, tmo, $urandom, AGENT_W'($urandom_range(0, 15)));
		end
		idle_on = 1'b1;
	endtask

	task automatic finish_run();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("one_shot_timer_bank_unit test passed");
		else
			$display("one_shot_timer_bank_unit test failed");
		$finish;
	endtask

	initial begin
		reset_bank();
		for (int i = 0; i < TIMER_COUNT; i++) begin
			slot_sig[i] = '0;
			slot_agent[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_bank();
		test_register_full();
		test_arm_rules();
		test_odd_codes();
		test_random_ops(96);
		finish_run();
	end

endmodule
